// ===== rtl/ratpg_pkg.sv =====
// Shared constants, register indexes and types for the AM tone raster generator.
package ratpg_pkg;

   localparam int COORD_BITS_DEFAULT      = 12;
   localparam int PHASE_FRAC_BITS_DEFAULT = 24;

   localparam int PHASE_BITS = 32;
   localparam int SIZE_BITS  = 13;
   localparam int SPAN_BITS  = 14;
   localparam int ADDR_BITS  = 5;
   localparam int DATA_BITS  = 32;
   localparam int SETTLE_CYCLES = 3;
   localparam int SETTLE_BITS   = 2;

   localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(640);
   localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(480);
   localparam logic [SPAN_BITS-1:0] SPAN_RESET   = SPAN_BITS'(800);

   typedef enum logic [2:0] {
      REG_TONE_INC    = 3'd0,
      REG_CARRIER_INC = 3'd1,
      REG_WIDTH       = 3'd2,
      REG_HEIGHT      = 3'd3,
      REG_SPAN        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0] tone_inc;
      logic [PHASE_BITS-1:0] carrier_inc;
      logic [PHASE_BITS-1:0] tone_line;
      logic [PHASE_BITS-1:0] carrier_line;
   } phase_step_type;

endpackage

// ===== rtl/ratpg_req_if.sv =====
// Request channel carrying the frame restart flag.
interface ratpg_req_if;
   logic valid;
   logic ready;
   logic start_frame;

   modport source (output valid, output start_frame, input ready);
   modport sink   (input valid, input start_frame, output ready);
endinterface

// ===== rtl/ratpg_rsp_if.sv =====
// Response channel carrying one generated pixel.
interface ratpg_rsp_if #(
   parameter int COORD_BITS = ratpg_pkg::COORD_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic                  pixel_on;
   logic [COORD_BITS-1:0] column;
   logic [COORD_BITS-1:0] row;
   logic                  frame_end;

   modport source (output valid, output pixel_on, output column, output row,
                   output frame_end, input ready);
   modport sink   (input valid, input pixel_on, input column, input row,
                   input frame_end, output ready);
endinterface

// ===== rtl/ratpg_csr.sv =====
// Configuration registers and precomputed per-line phase steps.
module ratpg_csr #(
   parameter int COORD_BITS = ratpg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ratpg_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [ratpg_pkg::DATA_BITS-1:0]   pwdata,
   output logic [ratpg_pkg::DATA_BITS-1:0]   prdata,
   output logic                              pready,
   output logic [COORD_BITS-1:0]             width_last,
   output logic [COORD_BITS-1:0]             height_last,
   output ratpg_pkg::phase_step_type         steps,
   output logic                              settling
);

   localparam int ExtBits = (COORD_BITS + 1 > ratpg_pkg::SPAN_BITS) ?
                            COORD_BITS + 1 : ratpg_pkg::SPAN_BITS;
   localparam logic [ExtBits-1:0] CoordLimit = ExtBits'(1) << COORD_BITS;

   logic [ratpg_pkg::PHASE_BITS-1:0] tone_inc_ff, tone_inc_in;
   logic [ratpg_pkg::PHASE_BITS-1:0] carrier_inc_ff, carrier_inc_in;
   logic [ratpg_pkg::SIZE_BITS-1:0]  width_ff, width_in;
   logic [ratpg_pkg::SIZE_BITS-1:0]  height_ff, height_in;
   logic [ratpg_pkg::SPAN_BITS-1:0]  span_ff, span_in;
   logic [ratpg_pkg::SETTLE_BITS-1:0] settle_ff, settle_in;

   logic [COORD_BITS-1:0]            width_last_ff, width_last_in;
   logic [COORD_BITS-1:0]            height_last_ff, height_last_in;
   logic [ratpg_pkg::SPAN_BITS-1:0]  gap_ff, gap_in;
   logic [ratpg_pkg::PHASE_BITS-1:0] tone_prod_ff, tone_prod_in;
   logic [ratpg_pkg::PHASE_BITS-1:0] carrier_prod_ff, carrier_prod_in;
   logic [ratpg_pkg::PHASE_BITS-1:0] tone_line_ff, tone_line_in;
   logic [ratpg_pkg::PHASE_BITS-1:0] carrier_line_ff, carrier_line_in;

   logic                             write_en;
   ratpg_pkg::csr_index_type         index;
   logic [ExtBits-1:0]               width_eff;
   logic [ExtBits-1:0]               height_eff;
   logic [ExtBits-1:0]               span_ext;

   function automatic logic [ExtBits-1:0] clamp_size(
      input logic [ratpg_pkg::SIZE_BITS-1:0] v
   );
      logic [ExtBits-1:0] ext;
      ext = ExtBits'(v);
      if (ext == '0) begin
         return ExtBits'(1);
      end else if (ext > CoordLimit) begin
         return CoordLimit;
      end
      return ext;
   endfunction

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;
   assign index    = ratpg_pkg::csr_index_type'(paddr[4:2]);

   always_comb begin
      tone_inc_in    = tone_inc_ff;
      carrier_inc_in = carrier_inc_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      span_in        = span_ff;
      prdata         = '0;
      unique case (index)
         ratpg_pkg::REG_TONE_INC: begin
            prdata = tone_inc_ff;
            if (write_en) tone_inc_in = pwdata;
         end
         ratpg_pkg::REG_CARRIER_INC: begin
            prdata = carrier_inc_ff;
            if (write_en) carrier_inc_in = pwdata;
         end
         ratpg_pkg::REG_WIDTH: begin
            prdata = ratpg_pkg::DATA_BITS'(width_ff);
            if (write_en) width_in = pwdata[ratpg_pkg::SIZE_BITS-1:0];
         end
         ratpg_pkg::REG_HEIGHT: begin
            prdata = ratpg_pkg::DATA_BITS'(height_ff);
            if (write_en) height_in = pwdata[ratpg_pkg::SIZE_BITS-1:0];
         end
         ratpg_pkg::REG_SPAN: begin
            prdata = ratpg_pkg::DATA_BITS'(span_ff);
            if (write_en) span_in = pwdata[ratpg_pkg::SPAN_BITS-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // hold off requests until the derived steps reflect the new settings
   always_comb begin
      if (write_en) begin
         settle_in = ratpg_pkg::SETTLE_BITS'(ratpg_pkg::SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_comb begin
      width_eff      = clamp_size(width_ff);
      height_eff     = clamp_size(height_ff);
      span_ext       = ExtBits'(span_ff);
      width_last_in  = COORD_BITS'(width_eff - 1'b1);
      height_last_in = COORD_BITS'(height_eff - 1'b1);
      gap_in         = (span_ext > width_eff) ?
                       ratpg_pkg::SPAN_BITS'(span_ext - width_eff) : '0;
      tone_prod_in    = ratpg_pkg::PHASE_BITS'(gap_ff) * tone_inc_ff;
      carrier_prod_in = ratpg_pkg::PHASE_BITS'(gap_ff) * carrier_inc_ff;
      tone_line_in    = tone_prod_ff + tone_inc_ff;
      carrier_line_in = carrier_prod_ff + carrier_inc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_inc_ff    <= '0;
         carrier_inc_ff <= '0;
         width_ff       <= ratpg_pkg::WIDTH_RESET;
         height_ff      <= ratpg_pkg::HEIGHT_RESET;
         span_ff        <= ratpg_pkg::SPAN_RESET;
         settle_ff      <= ratpg_pkg::SETTLE_BITS'(ratpg_pkg::SETTLE_CYCLES);
      end else begin
         tone_inc_ff    <= tone_inc_in;
         carrier_inc_ff <= carrier_inc_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         span_ff        <= span_in;
         settle_ff      <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      width_last_ff   <= width_last_in;
      height_last_ff  <= height_last_in;
      gap_ff          <= gap_in;
      tone_prod_ff    <= tone_prod_in;
      carrier_prod_ff <= carrier_prod_in;
      tone_line_ff    <= tone_line_in;
      carrier_line_ff <= carrier_line_in;
   end

   assign width_last         = width_last_ff;
   assign height_last        = height_last_ff;
   assign steps.tone_inc     = tone_inc_ff;
   assign steps.carrier_inc  = carrier_inc_ff;
   assign steps.tone_line    = tone_line_ff;
   assign steps.carrier_line = carrier_line_ff;
   assign settling           = (settle_ff != '0);

endmodule

// ===== rtl/raster_am_tone_pattern_gen.sv =====
// Top level: raster pixel generator whose light pattern carries an AM audio tone.
// An accepted request's pixel is registered and appears on the response channel in the cycle after.
// Throughput: one request per cycle; a request enters in the cycle the previous
// pixel is taken and is held off while that pixel waits.
// After reset, and after each register write, requests are held off while the
// per-line phase steps ((gap plus one) times increment) pass their registers.
// Reset clears counters, phases and registers to their documented values.
module raster_am_tone_pattern_gen #(
   parameter int COORD_BITS      = ratpg_pkg::COORD_BITS_DEFAULT,
   parameter int PHASE_FRAC_BITS = ratpg_pkg::PHASE_FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   ratpg_req_if.sink                       req,
   ratpg_rsp_if.source                     rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ratpg_pkg::ADDR_BITS-1:0] paddr,
   input  logic [ratpg_pkg::DATA_BITS-1:0] pwdata,
   output logic [ratpg_pkg::DATA_BITS-1:0] prdata,
   output logic                            pready
);

   logic [COORD_BITS-1:0]     width_last;
   logic [COORD_BITS-1:0]     height_last;
   ratpg_pkg::phase_step_type steps;
   logic                      settling;

   logic [ratpg_pkg::PHASE_BITS-1:0] tone_ff, tone_in;
   logic [ratpg_pkg::PHASE_BITS-1:0] carrier_ff, carrier_in;
   logic [COORD_BITS-1:0]            col_ff, col_in;
   logic [COORD_BITS-1:0]            row_ff, row_in;
   logic                             line_odd_ff, line_odd_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  pixel_on_ff, pixel_on_in;
   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [COORD_BITS-1:0] row_out_ff, row_out_in;
   logic                  frame_end_ff, frame_end_in;

   logic                             accept;
   logic [ratpg_pkg::PHASE_BITS-1:0] cur_tone;
   logic [ratpg_pkg::PHASE_BITS-1:0] cur_carrier;
   logic [COORD_BITS-1:0]            cur_col;
   logic [COORD_BITS-1:0]            cur_row;
   logic                             cur_odd;
   logic                             last_col;
   logic                             last_row;
   logic [ratpg_pkg::PHASE_BITS-1:0] line_tone;

   ratpg_csr #(
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .width_last  (width_last),
      .height_last (height_last),
      .steps       (steps),
      .settling    (settling)
   );

   assign req.ready = (!rsp_valid_ff || rsp.ready) && !settling;
   assign accept    = req.valid && req.ready;

   always_comb begin
      cur_tone    = req.start_frame ? '0 : tone_ff;
      cur_carrier = req.start_frame ? '0 : carrier_ff;
      cur_col     = req.start_frame ? '0 : col_ff;
      cur_row     = req.start_frame ? '0 : row_ff;
      cur_odd     = req.start_frame ? 1'b0 : line_odd_ff;
      last_col    = (cur_col >= width_last);
      last_row    = (cur_row >= height_last);
      line_tone   = cur_tone + steps.tone_line;

      pixel_on_in  = !cur_odd && cur_carrier[PHASE_FRAC_BITS];
      column_in    = cur_col;
      row_out_in   = cur_row;
      frame_end_in = last_col && last_row;

      tone_in     = tone_ff;
      carrier_in  = carrier_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      line_odd_in = line_odd_ff;
      if (accept) begin
         priority if (!last_col) begin
            tone_in     = cur_tone + steps.tone_inc;
            carrier_in  = cur_carrier + steps.carrier_inc;
            col_in      = cur_col + 1'b1;
            row_in      = cur_row;
            line_odd_in = cur_odd;
         end else if (last_row) begin
            tone_in     = '0;
            carrier_in  = '0;
            col_in      = '0;
            row_in      = '0;
            line_odd_in = 1'b0;
         end else begin
            tone_in     = line_tone;
            carrier_in  = cur_carrier + steps.carrier_line;
            col_in      = '0;
            row_in      = cur_row + 1'b1;
            line_odd_in = line_tone[PHASE_FRAC_BITS];
         end
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_ff      <= '0;
         carrier_ff   <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         line_odd_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tone_ff      <= tone_in;
         carrier_ff   <= carrier_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         line_odd_ff  <= line_odd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_on_ff  <= pixel_on_in;
         column_ff    <= column_in;
         row_out_ff   <= row_out_in;
         frame_end_ff <= frame_end_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.pixel_on  = pixel_on_ff;
   assign rsp.column    = column_ff;
   assign rsp.row       = row_out_ff;
   assign rsp.frame_end = frame_end_ff;

   a_settle_blocks: assert property (@(posedge clock) disable iff (reset)
      settling |-> !req.ready)
      else $error("request accepted while phase steps settle");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no pixel");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && last_col && last_row |=>
         col_ff == '0 && row_ff == '0 && tone_ff == '0 && carrier_ff == '0)
      else $error("frame end did not return to pixel zero");

   a_black_line: assert property (@(posedge clock) disable iff (reset)
      accept && cur_odd |=> !pixel_on_ff)
      else $error("pixel lit on a tone-odd line");

endmodule

// ===== tb/testbench.sv =====
// Testbench for the AM tone raster generator: directed table, random phases, pixel predictor.
module testbench;

   localparam int COORD_W = ratpg_pkg::COORD_BITS_DEFAULT;
   localparam int FRAC_W  = ratpg_pkg::PHASE_FRAC_BITS_DEFAULT;

   typedef struct packed {
      logic               pixel_on;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               frame_end;
   } pixel_type;

   typedef enum logic {STEP_WRITE, STEP_PIXEL} step_kind_type;

   typedef struct packed {
      step_kind_type            kind;
      ratpg_pkg::csr_index_type index;
      logic [31:0]              value;
      logic                     start;
      logic                     typed;
      pixel_type                want;
   } step_type;

   localparam int SCRIPT_LEN = 34;

   step_type script [0:SCRIPT_LEN-1] = '{
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b1, 1'b1, '{1'b0, 12'd0, 12'd0, 1'b0}},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b1, '{1'b0, 12'd1, 12'd0, 1'b0}},
      '{STEP_WRITE, ratpg_pkg::REG_CARRIER_INC, 32'h0100_0000, 1'b0, 1'b0, '0},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b1, 1'b1, '{1'b0, 12'd0, 12'd0, 1'b0}},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b1, '{1'b1, 12'd1, 12'd0, 1'b0}},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b1, '{1'b0, 12'd2, 12'd0, 1'b0}},
      '{STEP_WRITE, ratpg_pkg::REG_WIDTH,    32'd1, 1'b0, 1'b0, '0},
      '{STEP_WRITE, ratpg_pkg::REG_HEIGHT,   32'd1, 1'b0, 1'b0, '0},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b1, '{1'b1, 12'd3, 12'd0, 1'b1}},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b1, '{1'b0, 12'd0, 12'd0, 1'b1}},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b1, '{1'b0, 12'd0, 12'd0, 1'b1}},
      '{STEP_WRITE, ratpg_pkg::REG_WIDTH,    32'd0, 1'b0, 1'b0, '0},
      '{STEP_WRITE, ratpg_pkg::REG_HEIGHT,   32'd0, 1'b0, 1'b0, '0},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b1, '{1'b0, 12'd0, 12'd0, 1'b1}},
      '{STEP_WRITE, ratpg_pkg::REG_TONE_INC,    32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{STEP_WRITE, ratpg_pkg::REG_CARRIER_INC, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{STEP_WRITE, ratpg_pkg::REG_WIDTH,       32'h0000_1FFF, 1'b0, 1'b0, '0},
      '{STEP_WRITE, ratpg_pkg::REG_HEIGHT,      32'd4097,      1'b0, 1'b0, '0},
      '{STEP_WRITE, ratpg_pkg::REG_SPAN,        32'd0,         1'b0, 1'b0, '0},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b1, 1'b1, '{1'b0, 12'd0, 12'd0, 1'b0}},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b0, '0},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b0, '0},
      '{STEP_WRITE, ratpg_pkg::REG_WIDTH,       32'd2,         1'b0, 1'b0, '0},
      '{STEP_WRITE, ratpg_pkg::REG_HEIGHT,      32'd3,         1'b0, 1'b0, '0},
      '{STEP_WRITE, ratpg_pkg::REG_SPAN,        32'h0000_3FFF, 1'b0, 1'b0, '0},
      '{STEP_WRITE, ratpg_pkg::REG_TONE_INC,    32'h0100_0000, 1'b0, 1'b0, '0},
      '{STEP_WRITE, ratpg_pkg::REG_CARRIER_INC, 32'h0100_0000, 1'b0, 1'b0, '0},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b1, 1'b1, '{1'b0, 12'd0, 12'd0, 1'b0}},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b0, '0},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b0, '0},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b0, '0},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b0, '0},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b0, '0},
      '{STEP_PIXEL, ratpg_pkg::REG_TONE_INC, 32'd0, 1'b0, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [ratpg_pkg::ADDR_BITS-1:0] paddr;
   logic [ratpg_pkg::DATA_BITS-1:0] pwdata;
   logic [ratpg_pkg::DATA_BITS-1:0] prdata;
   logic                            pready;

   ratpg_req_if req ();
   ratpg_rsp_if rsp ();

   raster_am_tone_pattern_gen u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [ratpg_pkg::PHASE_BITS-1:0] tone_step    = '0;
   logic [ratpg_pkg::PHASE_BITS-1:0] carrier_step = '0;
   logic [ratpg_pkg::SIZE_BITS-1:0]  width_cfg    = ratpg_pkg::WIDTH_RESET;
   logic [ratpg_pkg::SIZE_BITS-1:0]  height_cfg   = ratpg_pkg::HEIGHT_RESET;
   logic [ratpg_pkg::SPAN_BITS-1:0]  span_cfg     = ratpg_pkg::SPAN_RESET;

   logic [ratpg_pkg::PHASE_BITS-1:0] tone_acc    = '0;
   logic [ratpg_pkg::PHASE_BITS-1:0] carrier_acc = '0;
   logic [COORD_W-1:0]               column_pos  = '0;
   logic [COORD_W-1:0]               row_pos     = '0;
   logic                             line_dark   = 1'b0;

   pixel_type   pending_pixels [$];
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;
   bit          steady         = 1'b0;
   bit          rsp_hold       = 1'b0;

   function automatic int unsigned effective_size(
      input logic [ratpg_pkg::SIZE_BITS-1:0] size
   );
      if (size == 0) return 1;
      if (size > (1 << COORD_W)) return 1 << COORD_W;
      return size;
   endfunction

   function automatic void restart_raster();
      tone_acc    = '0;
      carrier_acc = '0;
      column_pos  = '0;
      row_pos     = '0;
      line_dark   = 1'b0;
   endfunction

   function automatic pixel_type next_pixel(input logic start);
      int unsigned                      w;
      int unsigned                      h;
      logic [ratpg_pkg::PHASE_BITS-1:0] gap;
      logic                             last_col;
      logic                             last_row;
      pixel_type                        px;
      w = effective_size(width_cfg);
      h = effective_size(height_cfg);
      if (start) restart_raster();
      last_col = (column_pos >= w - 1);
      last_row = (row_pos >= h - 1);
      px.pixel_on  = !line_dark && carrier_acc[FRAC_W];
      px.column    = column_pos;
      px.row       = row_pos;
      px.frame_end = last_col && last_row;
      tone_acc    = tone_acc + tone_step;
      carrier_acc = carrier_acc + carrier_step;
      if (!last_col) begin
         column_pos = column_pos + 1'b1;
      end else if (last_row) begin
         restart_raster();
      end else begin
         gap = (span_cfg > w) ? ratpg_pkg::PHASE_BITS'(span_cfg - w) : '0;
         tone_acc    = tone_acc + gap * tone_step;
         carrier_acc = carrier_acc + gap * carrier_step;
         column_pos  = '0;
         row_pos     = row_pos + 1'b1;
         line_dark   = tone_acc[FRAC_W];
      end
      return px;
   endfunction

   function automatic int unsigned pause_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_increment();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom_range(0, 32'h0400_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_size(input int unsigned most);
      case ($urandom_range(0, 19))
         0:       return 0;
         1:       return 4096;
         2:       return 4097;
         3:       return 32'h1FFF;
         default: return $urandom_range(1, most);
      endcase
   endfunction

   function automatic logic [31:0] pick_span();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 32'h3FFF;
         2:       return $urandom_range(0, 32'h3FFF);
         default: return $urandom_range(0, 40);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %0h, want %0h", what, got, want);
      mismatch_count++;
   endtask

   task automatic csr_write(input ratpg_pkg::csr_index_type index,
                            input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ratpg_pkg::ADDR_BITS'({index, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (index)
         ratpg_pkg::REG_TONE_INC:    tone_step    = value;
         ratpg_pkg::REG_CARRIER_INC: carrier_step = value;
         ratpg_pkg::REG_WIDTH:       width_cfg    = value[ratpg_pkg::SIZE_BITS-1:0];
         ratpg_pkg::REG_HEIGHT:      height_cfg   = value[ratpg_pkg::SIZE_BITS-1:0];
         ratpg_pkg::REG_SPAN:        span_cfg     = value[ratpg_pkg::SPAN_BITS-1:0];
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic send_request(input logic start, input logic typed,
                               input pixel_type want);
      int unsigned gap;
      pixel_type   px;
      gap = pause_length();
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.start_frame <= start;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      px = next_pixel(start);
      pending_pixels.push_back(typed ? want : px);
   endtask

   initial begin : rsp_pacing
      int unsigned stall;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_hold = 1'b0;
            rsp.ready <= 1'b0;
            repeat (120) @(posedge clock);
         end else begin
            stall = pause_length();
            if (stall != 0) begin
               rsp.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : pixel_check
      pixel_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("pixel with no request", {rsp.column, rsp.row}, '0);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp.pixel_on !== want.pixel_on)
               report_mismatch("pixel_on", rsp.pixel_on, want.pixel_on);
            if (rsp.column !== want.column)
               report_mismatch("column", rsp.column, want.column);
            if (rsp.row !== want.row)
               report_mismatch("row", rsp.row, want.row);
            if (rsp.frame_end !== want.frame_end)
               report_mismatch("frame_end", rsp.frame_end, want.frame_end);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 4000) begin
         $display("FAIL raster_am_tone_pattern_gen");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned items;
      req.valid       <= 1'b0;
      req.start_frame <= 1'b0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == STEP_WRITE) begin
            wait_idle();
            csr_write(script[i].index, script[i].value);
         end else begin
            send_request(script[i].start, script[i].typed, script[i].want);
         end
      end

      for (int phase = 0; phase < 12; phase++) begin
         wait_idle();
         steady = (phase % 4 == 1);
         if ($urandom_range(0, 1)) csr_write(ratpg_pkg::REG_TONE_INC, pick_increment());
         if ($urandom_range(0, 1)) csr_write(ratpg_pkg::REG_CARRIER_INC, pick_increment());
         if ($urandom_range(0, 2) != 0) csr_write(ratpg_pkg::REG_WIDTH, pick_size(12));
         if ($urandom_range(0, 2) != 0) csr_write(ratpg_pkg::REG_HEIGHT, pick_size(8));
         if ($urandom_range(0, 1)) csr_write(ratpg_pkg::REG_SPAN, pick_span());
         if (phase == 3) rsp_hold = 1'b1;
         items = $urandom_range(35, 65);
         for (int k = 0; k < items; k++) begin
            if (phase == 6 && k == items / 2) wait_idle();
            send_request($urandom_range(0, 24) == 0, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS raster_am_tone_pattern_gen");
      else
         $display("FAIL raster_am_tone_pattern_gen");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ratpg_pkg.sv
rtl/ratpg_req_if.sv
rtl/ratpg_rsp_if.sv
rtl/ratpg_csr.sv
rtl/raster_am_tone_pattern_gen.sv
tb/testbench.sv
